// ===== design/kbd_pkg.sv =====
package kbd_pkg;

  // radix of the key text and the grouping of symbols between dashes
  localparam int unsigned RADIX     = 24;
  localparam int unsigned GROUP_LEN = 5;
  localparam logic [7:0]  DASH_CHAR = 8'h2D;

  // reciprocal of 3 scaled by 2^11, exact for dividends below 768
  localparam logic [9:0]  RECIP_3   = 10'd683;
  localparam int unsigned RECIP_SH  = 11;

  typedef logic [4:0] digit_t;

  // controls from the sequencer to the digit divider
  typedef struct packed {
    logic clear;
    logic step;
  } div_ctrl_t;

  // base-24 digit to ascii letter of the key alphabet
  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] c;
    case (d)
      5'd0:    c = "B";
      5'd1:    c = "C";
      5'd2:    c = "D";
      5'd3:    c = "F";
      5'd4:    c = "G";
      5'd5:    c = "H";
      5'd6:    c = "J";
      5'd7:    c = "K";
      5'd8:    c = "M";
      5'd9:    c = "P";
      5'd10:   c = "Q";
      5'd11:   c = "R";
      5'd12:   c = "T";
      5'd13:   c = "V";
      5'd14:   c = "W";
      5'd15:   c = "X";
      5'd16:   c = "Y";
      5'd17:   c = "2";
      5'd18:   c = "3";
      5'd19:   c = "4";
      5'd20:   c = "6";
      5'd21:   c = "7";
      5'd22:   c = "8";
      5'd23:   c = "9";
      default: c = "B";
    endcase
    return c;
  endfunction

endpackage

// ===== design/kbd_byte_ram.sv =====
module kbd_byte_ram #(
  parameter int DEPTH  = 15,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kbd_digit_div.sv =====
module kbd_digit_div (
  input  logic              clk,
  input  kbd_pkg::div_ctrl_t ctrl,
  input  logic [7:0]        digit,
  output logic [7:0]        quot,
  output kbd_pkg::digit_t   rem
);
  import kbd_pkg::*;

  logic [12:0] acc;
  logic [9:0]  acc_div8;
  logic [19:0] prod;
  logic [12:0] quot_x24;
  logic [12:0] rem_full;

  // one byte of the long division by 24: acc / 24 = (acc / 8) / 3
  assign acc      = {rem, digit};
  assign acc_div8 = acc[12:3];
  assign prod     = acc_div8 * RECIP_3;
  assign quot     = prod[RECIP_SH +: 8];
  assign quot_x24 = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0};
  assign rem_full = acc - quot_x24;

  // running remainder carried from byte to byte
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      rem <= '0;
    end else if (ctrl.step) begin
      rem <= rem_full[4:0];
    end
  end

endmodule

// ===== design/base24_key_symbol_decoder.sv =====
// Takes a key one byte per transaction, least significant byte first, and on
// the transaction with tlast set decodes the stored KEY_BYTE_COUNT-byte
// little-endian number into SYMBOL_COUNT base-24 letters, sent highest text
// position first with a dash after every fifth letter; tlast on the output
// marks position 0. Bytes beyond KEY_BYTE_COUNT are dropped; a short key
// reuses the upper bytes left by the previous decode. Each letter comes from
// a long division by 24 that walks the key store top byte first, each byte
// with a registered ram read and then a divide and write back; the letter
// and each dash are sent as soon as the output is free. No input is taken
// while a key is being decoded.
module base24_key_symbol_decoder #(
  parameter int KEY_BYTE_COUNT = 15,
  parameter int SYMBOL_COUNT   = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // key_byte[7:0]
  input  logic        s_tlast,  // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // key_char[7:0], char_position[12:8], zero[15:13]
  output logic        m_tlast   // end_of_text
);
  import kbd_pkg::*;

  localparam int TOTAL_CHARS = SYMBOL_COUNT + (SYMBOL_COUNT - 1) / GROUP_LEN;
  localparam int POS_W  = (TOTAL_CHARS > 1) ? $clog2(TOTAL_CHARS) : 1;
  localparam int SYM_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int KIDX_W = (KEY_BYTE_COUNT > 1) ? $clog2(KEY_BYTE_COUNT) : 1;
  localparam int CNT_W  = $clog2(KEY_BYTE_COUNT + 1);
  localparam int GRP_INIT = (SYMBOL_COUNT - 1) % GROUP_LEN;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_DASH = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  loaded;
  logic [KIDX_W-1:0] idx;
  logic [SYM_W-1:0]  sym;
  logic [2:0]        grp;
  logic [POS_W-1:0]  pos;
  logic [POS_W+4:0]  pos_ext;

  logic [7:0]        out_char;
  logic [4:0]        out_pos;

  logic              s_acc;
  logic              out_free;
  logic              room;
  logic              ram_we;
  logic [KIDX_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [7:0]        quot;
  digit_t            rem;
  div_ctrl_t         div_ctrl;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign room     = loaded < CNT_W'(KEY_BYTE_COUNT);
  assign pos_ext  = {5'b0, pos};

  // store write: key bytes while loading, quotient bytes while dividing
  always_comb begin
    if (state == ST_CALC) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = quot;
    end else begin
      ram_we    = s_acc && room;
      ram_waddr = loaded[KIDX_W-1:0];
      ram_wdata = s_tdata;
    end
  end

  // divider controls: fresh remainder at the start of every letter
  always_comb begin
    div_ctrl.step  = (state == ST_CALC);
    div_ctrl.clear = (s_acc && s_tlast) ||
                     (state == ST_EMIT && out_free) ||
                     (state == ST_DASH && out_free);
  end

  kbd_byte_ram #(
    .DEPTH  (KEY_BYTE_COUNT),
    .ADDR_W (KIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  kbd_digit_div u_div (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .digit (ram_rdata),
    .quot  (quot),
    .rem   (rem)
  );

  // sequencer: load bytes, then one division pass per letter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      loaded <= '0;
      idx    <= '0;
      sym    <= '0;
      grp    <= '0;
      pos    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tlast) begin
              loaded <= '0;
              idx    <= KIDX_W'(KEY_BYTE_COUNT - 1);
              sym    <= SYM_W'(SYMBOL_COUNT - 1);
              grp    <= 3'(GRP_INIT);
              pos    <= POS_W'(TOTAL_CHARS - 1);
              state  <= ST_RD;
            end else if (room) begin
              loaded <= loaded + 1'b1;
            end
          end
        end
        ST_RD: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (idx == '0) begin
            state <= ST_EMIT;
          end else begin
            idx   <= idx - 1'b1;
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            pos <= pos - 1'b1;
            if (sym == '0) begin
              state <= ST_IDLE;
            end else if (grp == '0) begin
              state <= ST_DASH;
            end else begin
              sym   <= sym - 1'b1;
              grp   <= grp - 1'b1;
              idx   <= KIDX_W'(KEY_BYTE_COUNT - 1);
              state <= ST_RD;
            end
          end
        end
        ST_DASH: begin
          if (out_free) begin
            pos   <= pos - 1'b1;
            sym   <= sym - 1'b1;
            grp   <= 3'(GROUP_LEN - 1);
            idx   <= KIDX_W'(KEY_BYTE_COUNT - 1);
            state <= ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: holds one character until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= (state == ST_EMIT) || (state == ST_DASH);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == ST_EMIT || state == ST_DASH)) begin
      out_char <= (state == ST_EMIT) ? digit_char(rem) : DASH_CHAR;
      out_pos  <= pos_ext[4:0];
      m_tlast  <= (pos == '0);
    end
  end

  assign m_tdata = {3'b0, out_pos, out_char};

endmodule

// ===== verif/tb_base24_key_symbol_decoder.sv =====
module tb_base24_key_symbol_decoder;
  import kbd_pkg::*;

  localparam int KEY_LEN = 15;
  localparam int SYMBOLS = 25;
  // letters of the key text, digit 0 in the top byte
  localparam logic [8*24-1:0] KEY_ALPHABET = "BCDFGHJKMPQRTVWXY2346789";

  typedef struct packed {
    logic [7:0] key_char;
    logic [4:0] char_position;
    logic       end_of_text;
  } key_text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // key_byte[7:0]
  logic        s_tlast = 1'b0;   // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // key_char[7:0], char_position[12:8], zero[15:13]
  logic        m_tlast;          // end_of_text

  // predictor state: key byte store and load count
  logic [7:0]     key_store [KEY_LEN];
  int unsigned    bytes_stored = 0;
  key_text_char_t expected_chars [$];
  int             mismatches = 0;
  int             burst_left = 4;
  int unsigned    ready_mode = 0;
  int unsigned    ready_cycle = 0;

  base24_key_symbol_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // long division of the stored number by the radix, in place, top byte first
  function automatic int unsigned divide_store_by_radix();
    int unsigned acc;
    int unsigned rem;
    rem = 0;
    for (int i = KEY_LEN - 1; i >= 0; i--) begin
      acc = (rem << 8) | key_store[i];
      key_store[i] = 8'(acc / RADIX);
      rem = acc % RADIX;
    end
    return rem;
  endfunction

  function automatic void push_char(input logic [7:0] c, input int unsigned pos);
    key_text_char_t ch;
    ch.key_char      = c;
    ch.char_position = pos[4:0];
    ch.end_of_text   = (pos == 0);
    expected_chars.push_back(ch);
  endfunction

  // store one key byte; on the final byte decode the whole key text
  task automatic predict_key_byte(input logic [7:0] b, input logic fin);
    int unsigned pos;
    int unsigned rem;
    if (bytes_stored < KEY_LEN) begin
      key_store[bytes_stored] = b;
      bytes_stored++;
    end
    if (fin) begin
      pos = SYMBOLS + (SYMBOLS - 1) / GROUP_LEN - 1;
      for (int s = SYMBOLS - 1; s >= 0; s--) begin
        rem = divide_store_by_radix();
        push_char(KEY_ALPHABET[8*(RADIX-1-rem) +: 8], pos);
        pos--;
        if (s != 0 && s % GROUP_LEN == 0) begin
          push_char(DASH_CHAR, pos);
          pos--;
        end
      end
      bytes_stored = 0;
    end
  endtask

  // drive one key byte, wait for the transaction, then maybe pause between bursts
  task automatic send_key_byte(input logic [7:0] b, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    predict_key_byte(b, fin);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  // largest number, with two excess bytes that must be dropped
  task automatic test_max_key_with_excess();
    for (int i = 0; i < KEY_LEN + 2; i++)
      send_key_byte(8'hFF, i == KEY_LEN + 1);
  endtask

  // the previous quotient sits in byte 0 only, so one zero byte gives a zero key
  task automatic test_zero_key();
    send_key_byte(8'h00, 1'b1);
  endtask

  // short key reusing the upper bytes left by the previous decode
  task automatic test_short_key();
    send_key_byte(8'h80, 1'b0);
    send_key_byte(8'h01, 1'b1);
  endtask

  // mostly full keys, some short and some with excess bytes
  task automatic test_random_keys(input int item_goal);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < item_goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 70)      len = KEY_LEN;
      else if (kind < 85) len = $urandom_range(1, KEY_LEN - 1);
      else                len = $urandom_range(KEY_LEN + 1, KEY_LEN + 5);
      for (int i = 0; i < len; i++)
        send_key_byte(8'($urandom_range(0, 255)), i == len - 1);
      sent += len;
    end
  endtask

  // receiver stall pattern: always ready, randomly ready or a periodic pattern, the mode redrawn at random
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 97 == 0)
      ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (ready_cycle % 5 < 2);
    endcase
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk) begin : check_chars
    key_text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: tdata %h tlast %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata[7:0] !== want.key_char) begin
          $error("key_char: expected %h, got %h", want.key_char, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[12:8] !== want.char_position) begin
          $error("char_position: expected %0d, got %0d", want.char_position, m_tdata[12:8]);
          mismatches++;
        end
        if (m_tlast !== want.end_of_text) begin
          $error("end_of_text: expected %b, got %b", want.end_of_text, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_max_key_with_excess();
    test_zero_key();
    test_short_key();
    test_random_keys(150);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
